/* rtl/gbw_pkg.sv */
// Shared types and constants for the Gaussian blur window unit.
// No dependencies; imported by every module of the block except gbw_ram.
package gbw_pkg;

    localparam int MAX_RADIUS   = 3;
    localparam int TABLE_SIDE   = 2 * MAX_RADIUS + 1;
    localparam int TABLE_DEPTH  = TABLE_SIDE * TABLE_SIDE;
    localparam int WIDX_W       = $clog2(TABLE_DEPTH);
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_COLORS   = 4;
    localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_COLORS;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int WEIGHT_W     = 18;
    localparam int PIXEL_W      = 8;
    localparam int FRAC_BITS    = 16;
    localparam int PROD_W       = WEIGHT_W + PIXEL_W;
    localparam int ACC_W        = 32;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COLORS = 2'd2;
    localparam logic [1:0] REG_RADIUS = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [8:0] w;
        logic [8:0] h;
        logic [2:0] nc;
        logic [1:0] rad;
    } t_geom;

    typedef struct packed {
        logic clear;
        logic tap;
        logic last;
    } t_mac_ctrl;

    typedef struct packed {
        logic       done;
        logic [7:0] blurred;
        logic       saturated;
    } t_mac_stat;

endpackage

/* rtl/gbw_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module gbw_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/gbw_mac.sv */
// Shared multiply-accumulate unit: one weight*pixel per cycle, then clamp.
// Depends on gbw_pkg.
module gbw_mac (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gbw_pkg::t_mac_ctrl         i_ctrl,
    input  logic [gbw_pkg::WEIGHT_W-1:0] i_weight,
    input  logic [gbw_pkg::PIXEL_W-1:0]  i_pixel,
    output gbw_pkg::t_mac_stat         o_stat
);
    import gbw_pkg::*;

    logic              r_tap1, r_last1;
    logic              r_last2;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic              r_done;
    logic [ACC_W-FRAC_BITS-1:0] whole;
    logic              sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_tap1  <= 1'b0;
            r_last1 <= 1'b0;
            r_last2 <= 1'b0;
            r_prod  <= '0;
            r_acc   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_tap1  <= i_ctrl.tap;
            r_last1 <= i_ctrl.last;
            r_prod  <= r_tap1 ? PROD_W'(i_weight) * PROD_W'(i_pixel) : '0;
            r_last2 <= r_last1;
            r_acc   <= r_acc + ACC_W'(r_prod);
            r_done  <= r_last2;
        end
    end

    assign whole = r_acc[ACC_W-1:FRAC_BITS];
    assign sat   = |whole[ACC_W-FRAC_BITS-1:8];

    assign o_stat.done      = r_done;
    assign o_stat.saturated = sat;
    assign o_stat.blurred   = sat ? 8'hFF : whole[7:0];

endmodule

/* rtl/gbw_seq.sv */
// Sequencer: request decode, store write strobes and window tap walk.
// Depends on gbw_pkg.
module gbw_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [1:0]                    i_operation,
    input  logic [7:0]                    i_col,
    input  logic [7:0]                    i_row,
    input  logic [1:0]                    i_channel,
    input  logic [2:0]                    i_weight_row_offset,
    input  logic [2:0]                    i_weight_col_offset,
    input  gbw_pkg::t_geom                i_geom,
    input  logic                          i_mac_done,
    input  logic                          i_slot_free,
    output logic                          o_busy,
    output logic                          o_frame_we,
    output logic [gbw_pkg::STORE_AW-1:0]  o_frame_addr,
    output logic                          o_weight_we,
    output logic [gbw_pkg::WIDX_W-1:0]    o_weight_addr,
    output gbw_pkg::t_mac_ctrl            o_mac_ctrl,
    output logic                          o_out_load
);
    import gbw_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_dr, r_dc;
    logic [7:0] r_row, r_col;
    logic [1:0] r_ch, r_rad;
    logic [2:0] span;
    logic       in_image, is_compute, last_tap;
    logic [9:0] tap_row, tap_col;
    logic       tap_ok;
    logic [2:0] wt_row, wt_col;
    logic [WIDX_W-1:0] run_widx, load_widx;

    assign in_image = ({1'b0, i_col} < i_geom.w) && ({1'b0, i_row} < i_geom.h)
                   && ({1'b0, i_channel} < i_geom.nc);
    assign is_compute = i_accept && (i_operation == OP_COMPUTE);

    assign span     = {r_rad, 1'b0};
    assign last_tap = (r_dr == span) && (r_dc == span);

    assign tap_row = {2'b00, r_row} + {7'b0, r_dr} - {8'b0, r_rad};
    assign tap_col = {2'b00, r_col} + {7'b0, r_dc} - {8'b0, r_rad};
    assign tap_ok  = !tap_row[9] && (tap_row[8:0] < i_geom.h)
                  && !tap_col[9] && (tap_col[8:0] < i_geom.w);

    assign wt_row    = r_dr + 3'(MAX_RADIUS) - {1'b0, r_rad};
    assign wt_col    = r_dc + 3'(MAX_RADIUS) - {1'b0, r_rad};
    assign run_widx  = WIDX_W'(wt_row) * WIDX_W'(TABLE_SIDE) + WIDX_W'(wt_col);
    assign load_widx = WIDX_W'(i_weight_row_offset) * WIDX_W'(TABLE_SIDE)
                     + WIDX_W'(i_weight_col_offset);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (is_compute) begin
                    n_state = in_image ? ST_RUN : ST_RESULT;
                end
            end
            ST_RUN: begin
                if (last_tap) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_mac_done) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (i_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy         = 1'b1;
        o_frame_we     = 1'b0;
        o_weight_we    = 1'b0;
        o_frame_addr   = {tap_row[7:0], tap_col[7:0], r_ch};
        o_weight_addr  = run_widx;
        o_mac_ctrl     = '0;
        o_out_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy         = 1'b0;
                o_frame_addr   = {i_row, i_col, i_channel};
                o_weight_addr  = load_widx;
                o_frame_we     = i_accept && (i_operation == OP_WRITE) && in_image;
                o_weight_we    = i_accept && (i_operation == OP_LOAD)
                              && (i_weight_row_offset < 3'(TABLE_SIDE))
                              && (i_weight_col_offset < 3'(TABLE_SIDE));
                o_mac_ctrl.clear = is_compute;
            end
            ST_RUN: begin
                o_mac_ctrl.tap  = tap_ok;
                o_mac_ctrl.last = last_tap;
            end
            ST_DRAIN: begin
            end
            ST_RESULT: begin
                o_out_load = i_slot_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dr    <= '0;
            r_dc    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_dr <= '0;
                r_dc <= '0;
            end else if (r_state == ST_RUN) begin
                if (r_dc == span) begin
                    r_dc <= '0;
                    r_dr <= r_dr + 3'd1;
                end else begin
                    r_dc <= r_dc + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_compute && (r_state == ST_IDLE)) begin
            r_row <= i_row;
            r_col <= i_col;
            r_ch  <= i_channel;
            r_rad <= i_geom.rad;
        end
    end

endmodule

/* rtl/gaussian_blur_window_unit.sv */
// Top level of the Gaussian blur window unit: config registers, stores,
// sequencer, MAC unit and result register. Depends on gbw_pkg, gbw_ram,
// gbw_seq and gbw_mac.
//
// Requests arrive on the i_in_valid / o_in_stall channel and are taken at an
// edge with valid high and stall low. A load-weight or write-pixel request
// is written into its store at the accepting edge and does not stall the
// input. A compute request walks the (2*radius+1)^2 window through the
// single MAC unit, one tap per cycle from the frame store and weight table
// ports, waits in a drain state until the MAC reports done, then loads the
// result register and returns to idle to take the next request. A compute
// outside the image skips the walk and the drain and goes to the result.
// The input stalls for the whole compute. Results leave on o_out_valid /
// i_out_stall from a result register; a request may be accepted while a
// result waits, and a new compute holds its result until the register frees.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle, clears
// the result valid flag and restores the config registers. Frame store
// and weight table contents are not cleared and must be written before use.
// Registers on the APB port: 0x0 width, 0x4 height, 0x8 colors, 0xC radius.
module gaussian_blur_window_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_col,
    input  logic [7:0]  i_row,
    input  logic [1:0]  i_channel,
    input  logic [7:0]  i_pixel_value,
    input  logic [2:0]  i_weight_row_offset,
    input  logic [2:0]  i_weight_col_offset,
    input  logic [17:0] i_weight_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_blurred_value,
    output logic        o_saturated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gbw_pkg::*;

    logic [8:0] r_width, r_height;
    logic [2:0] r_colors;
    logic [1:0] r_radius;
    t_geom      geom;
    logic       cfg_we, accept, busy, slot_free, out_load;
    logic       frame_we, weight_we;
    logic [STORE_AW-1:0] frame_addr;
    logic [WIDX_W-1:0]   weight_addr;
    logic [PIXEL_W-1:0]  frame_rdata;
    logic [WEIGHT_W-1:0] weight_rdata;
    t_mac_ctrl  mac_ctrl;
    t_mac_stat  mac_stat;
    logic       r_out_valid, r_sat;
    logic [7:0] r_blur;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_colors <= 3'd1;
            r_radius <= 2'd1;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_WIDTH:  r_width  <= pwdata[8:0];
                REG_HEIGHT: r_height <= pwdata[8:0];
                REG_COLORS: r_colors <= pwdata[2:0];
                REG_RADIUS: r_radius <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = {23'b0, r_width};
            REG_HEIGHT: prdata = {23'b0, r_height};
            REG_COLORS: prdata = {29'b0, r_colors};
            REG_RADIUS: prdata = {30'b0, r_radius};
            default:    prdata = '0;
        endcase
    end

    assign geom.w   = (r_width  > 9'(MAX_WIDTH))  ? 9'(MAX_WIDTH)  : r_width;
    assign geom.h   = (r_height > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : r_height;
    assign geom.nc  = (r_colors > 3'(MAX_COLORS)) ? 3'(MAX_COLORS) : r_colors;
    assign geom.rad = (r_radius > 2'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : r_radius;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;
    assign slot_free  = !r_out_valid || !i_out_stall;

    gbw_seq u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (accept),
        .i_operation         (i_operation),
        .i_col               (i_col),
        .i_row               (i_row),
        .i_channel           (i_channel),
        .i_weight_row_offset (i_weight_row_offset),
        .i_weight_col_offset (i_weight_col_offset),
        .i_geom              (geom),
        .i_mac_done          (mac_stat.done),
        .i_slot_free         (slot_free),
        .o_busy              (busy),
        .o_frame_we          (frame_we),
        .o_frame_addr        (frame_addr),
        .o_weight_we         (weight_we),
        .o_weight_addr       (weight_addr),
        .o_mac_ctrl          (mac_ctrl),
        .o_out_load          (out_load)
    );

    gbw_ram #(.WIDTH(PIXEL_W), .DEPTH(STORE_DEPTH)) u_frame (
        .i_clk   (i_clk),
        .i_we    (frame_we),
        .i_addr  (frame_addr),
        .i_wdata (i_pixel_value),
        .o_rdata (frame_rdata)
    );

    gbw_ram #(.WIDTH(WEIGHT_W), .DEPTH(TABLE_DEPTH)) u_weight (
        .i_clk   (i_clk),
        .i_we    (weight_we),
        .i_addr  (weight_addr),
        .i_wdata (i_weight_value),
        .o_rdata (weight_rdata)
    );

    gbw_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_weight (weight_rdata),
        .i_pixel  (frame_rdata),
        .o_stat   (mac_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_blur <= mac_stat.blurred;
            r_sat  <= mac_stat.saturated;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_blurred_value = r_blur;
    assign o_saturated     = r_sat;

    a_sat_clamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> o_blurred_value == 8'hFF)
        else $error("saturated result not clamped");

    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (frame_we || weight_we) |-> !mac_ctrl.tap && !busy)
        else $error("store write during window walk");

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_stat.done |-> busy)
        else $error("MAC done outside a compute");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result overwrites a pending result");

endmodule

/* test/testbench.sv */
// Self-checking testbench for gaussian_blur_window_unit: directed edge cases, then random
// request traffic under several geometries, each result checked against a shadow predictor.
// Depends on rtl/gbw_pkg.sv and the gaussian_blur_window_unit RTL.
module testbench;
    import gbw_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        bit [1:0]  op;
        bit [7:0]  col;
        bit [7:0]  row;
        bit [1:0]  ch;
        bit [7:0]  pix;
        bit [2:0]  wr;
        bit [2:0]  wc;
        bit [17:0] wv;
    } t_blur_req;

    typedef struct packed {
        bit [7:0] value;
        bit       sat;
    } t_blur_pix;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = '0;
    logic [7:0]  col = '0;
    logic [7:0]  row = '0;
    logic [1:0]  channel = '0;
    logic [7:0]  pixel_value = '0;
    logic [2:0]  weight_row = '0;
    logic [2:0]  weight_col = '0;
    logic [17:0] weight_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  blurred;
    logic        saturated;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow copy of the block state
    bit [7:0]  shadow_frame [STORE_DEPTH];
    bit        pixel_written [STORE_DEPTH];
    bit [17:0] shadow_kernel [TABLE_SIDE][TABLE_SIDE];
    bit [8:0]  geo_w = 9'd256;
    bit [8:0]  geo_h = 9'd256;
    bit [2:0]  geo_nc = 3'd1;
    bit [1:0]  geo_rad = 2'd1;

    t_blur_pix pending_pixels[$];
    t_blur_pix expected_head;
    int        mismatch_count = 0;
    int        useful_count = 0;
    int        burst_left = 0;
    bit        hold_request = 1'b0;
    int        idle_cycles = 0;

    gaussian_blur_window_unit DUT (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_operation         (operation),
        .i_col               (col),
        .i_row               (row),
        .i_channel           (channel),
        .i_pixel_value       (pixel_value),
        .i_weight_row_offset (weight_row),
        .i_weight_col_offset (weight_col),
        .i_weight_value      (weight_value),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_blurred_value     (blurred),
        .o_saturated         (saturated),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #1 clk = ~clk;

    function automatic int eff_width();
        return (geo_w > MAX_WIDTH) ? MAX_WIDTH : int'(geo_w);
    endfunction

    function automatic int eff_height();
        return (geo_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(geo_h);
    endfunction

    function automatic int eff_colors();
        return (geo_nc > MAX_COLORS) ? MAX_COLORS : int'(geo_nc);
    endfunction

    function automatic int eff_radius();
        return (geo_rad > MAX_RADIUS) ? MAX_RADIUS : int'(geo_rad);
    endfunction

    function automatic int frame_index(int c, int r, int ch);
        return (r * MAX_WIDTH + c) * MAX_COLORS + ch;
    endfunction

    function automatic bit is_inside(int c, int r, int ch);
        return c < eff_width() && r < eff_height() && ch < eff_colors();
    endfunction

    // Applies one accepted request to the shadow state; returns 1 unless it is ignored.
    function automatic bit predict_request(t_blur_req q);
        longint unsigned acc;
        longint unsigned whole;
        int rad;
        int rr;
        int cc;
        t_blur_pix res;
        acc = 0;
        res = '0;
        case (q.op)
            OP_LOAD: begin
                if (q.wr < TABLE_SIDE && q.wc < TABLE_SIDE) begin
                    shadow_kernel[q.wr][q.wc] = q.wv;
                    return 1'b1;
                end
                return 1'b0;
            end
            OP_WRITE: begin
                if (is_inside(q.col, q.row, q.ch)) begin
                    shadow_frame[frame_index(q.col, q.row, q.ch)] = q.pix;
                    pixel_written[frame_index(q.col, q.row, q.ch)] = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            OP_COMPUTE: begin
                if (is_inside(q.col, q.row, q.ch)) begin
                    rad = eff_radius();
                    for (int dr = -rad; dr <= rad; dr++) begin
                        rr = int'(q.row) + dr;
                        if (rr < 0 || rr >= eff_height()) continue;
                        for (int dc = -rad; dc <= rad; dc++) begin
                            cc = int'(q.col) + dc;
                            if (cc < 0 || cc >= eff_width()) continue;
                            acc += longint'(shadow_kernel[dr + MAX_RADIUS][dc + MAX_RADIUS])
                                 * longint'(shadow_frame[frame_index(cc, rr, q.ch)]);
                        end
                    end
                    whole = acc >> FRAC_BITS;
                    res.sat = whole > 255;
                    res.value = res.sat ? 8'd255 : whole[7:0];
                end
                pending_pixels.push_back(res);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_blur_req random_fields();
        t_blur_req q;
        q.op  = 2'($urandom_range(0, 3));
        q.col = 8'($urandom_range(0, 255));
        q.row = 8'($urandom_range(0, 255));
        q.ch  = 2'($urandom_range(0, 3));
        q.pix = 8'($urandom_range(0, 255));
        q.wr  = 3'($urandom_range(0, 7));
        q.wc  = 3'($urandom_range(0, 7));
        q.wv  = 18'($urandom_range(0, 262143));
        return q;
    endfunction

    function automatic int pick_coord(int ext);
        int span;
        int roll;
        if (ext == 0) return $urandom_range(0, 255);
        span = (ext < 5) ? ext : 5;
        roll = $urandom_range(0, 9);
        if (roll < 4) return $urandom_range(0, span - 1);
        if (roll < 8) return ext - 1 - $urandom_range(0, span - 1);
        if (roll == 8) return $urandom_range(0, 255);
        return $urandom_range(0, ext - 1);
    endfunction

    function automatic int pick_channel();
        if (eff_colors() == 0 || $urandom_range(0, 4) == 0) return $urandom_range(0, 3);
        return $urandom_range(0, eff_colors() - 1);
    endfunction

    task automatic send_request(t_blur_req q);
        int gap;
        gap = (burst_left > 0) ? 0 : $urandom_range(0, 5);
        if (burst_left > 0) burst_left--;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= q.op;
        col          <= q.col;
        row          <= q.row;
        channel      <= q.ch;
        pixel_value  <= q.pix;
        weight_row   <= q.wr;
        weight_col   <= q.wc;
        weight_value <= q.wv;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        if (predict_request(q)) useful_count++;
        @(posedge clk);
    endtask

    task automatic write_pixel(int c, int r, int ch, int v);
        t_blur_req q;
        q = random_fields();
        q.op  = OP_WRITE;
        q.col = c[7:0];
        q.row = r[7:0];
        q.ch  = ch[1:0];
        q.pix = v[7:0];
        send_request(q);
    endtask

    task automatic load_weight(int wr, int wc, int v);
        t_blur_req q;
        q = random_fields();
        q.op = OP_LOAD;
        q.wr = wr[2:0];
        q.wc = wc[2:0];
        q.wv = v[17:0];
        send_request(q);
    endtask

    task automatic compute_at(int c, int r, int ch);
        t_blur_req q;
        q = random_fields();
        q.op  = OP_COMPUTE;
        q.col = c[7:0];
        q.row = r[7:0];
        q.ch  = ch[1:0];
        send_request(q);
    endtask

    // every neighbor a compute will read gets written first
    task automatic fill_window(int c, int r, int ch);
        int rad;
        rad = eff_radius();
        if (!is_inside(c, r, ch)) return;
        for (int rr = r - rad; rr <= r + rad; rr++) begin
            for (int cc = c - rad; cc <= c + rad; cc++) begin
                if (rr < 0 || cc < 0 || !is_inside(cc, rr, ch)) continue;
                if (!pixel_written[frame_index(cc, rr, ch)])
                    write_pixel(cc, rr, ch, $urandom_range(0, 255));
            end
        end
    endtask

    task automatic load_kernel(int scale);
        int d;
        for (int i = 0; i < TABLE_SIDE; i++) begin
            for (int j = 0; j < TABLE_SIDE; j++) begin
                d = ((i > MAX_RADIUS) ? i - MAX_RADIUS : MAX_RADIUS - i)
                  + ((j > MAX_RADIUS) ? j - MAX_RADIUS : MAX_RADIUS - j);
                load_weight(i, j, (scale >> d) + $urandom_range(0, scale >> (d + 2)));
            end
        end
    endtask

    task automatic apb_access(logic [1:0] idx, bit wr, logic [31:0] data,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rdata = prdata;
        @(posedge clk);
    endtask

    function automatic logic [31:0] reg_mask(logic [1:0] idx);
        case (idx)
            REG_WIDTH, REG_HEIGHT: return 32'h1FF;
            REG_COLORS:            return 32'h7;
            default:               return 32'h3;
        endcase
    endfunction

    function automatic logic [31:0] reg_shadow(logic [1:0] idx);
        case (idx)
            REG_WIDTH:  return 32'(geo_w);
            REG_HEIGHT: return 32'(geo_h);
            REG_COLORS: return 32'(geo_nc);
            default:    return 32'(geo_rad);
        endcase
    endfunction

    task automatic write_register(logic [1:0] idx, int value);
        logic [31:0] data;
        logic [31:0] rd;
        data = ($urandom() & ~reg_mask(idx)) | (value & reg_mask(idx));
        apb_access(idx, 1'b1, data, rd);
        case (idx)
            REG_WIDTH:  geo_w = data[8:0];
            REG_HEIGHT: geo_h = data[8:0];
            REG_COLORS: geo_nc = data[2:0];
            default:    geo_rad = data[1:0];
        endcase
    endtask

    task automatic check_register(logic [1:0] idx);
        logic [31:0] rd;
        apb_access(idx, 1'b0, '0, rd);
        if (rd !== reg_shadow(idx)) begin
            $display("%0t: register %0d expected %0h got %0h", $time, idx, reg_shadow(idx), rd);
            mismatch_count++;
        end
    endtask

    task automatic check_all_registers();
        check_register(REG_WIDTH);
        check_register(REG_HEIGHT);
        check_register(REG_COLORS);
        check_register(REG_RADIUS);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_pixels.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(int w, int h, int nc, int rad);
        drain();
        write_register(REG_WIDTH, w);
        write_register(REG_HEIGHT, h);
        write_register(REG_COLORS, nc);
        write_register(REG_RADIUS, rad);
        check_all_registers();
    endtask

    task automatic test_reset_defaults();
        check_all_registers();
    endtask

    task automatic test_default_geometry();
        t_blur_req q;
        load_kernel(20000);
        fill_window(255, 255, 0);
        compute_at(255, 255, 0);
        fill_window(0, 0, 0);
        compute_at(0, 0, 0);
        write_pixel(0, 0, 1, 77);   // channel beyond count: ignored
        compute_at(0, 0, 1);
        compute_at(128, 40, 3);
        q = '1;
        q.op = OP_UNUSED;
        send_request(q);
        compute_at(0, 0, 0);
    endtask

    // radius 0: only the center tap counts, so the clamp boundary is exact
    task automatic test_saturation_edge();
        set_geometry(3, 2, 4, 0);
        write_pixel(2, 1, 3, 255);
        load_weight(MAX_RADIUS, MAX_RADIUS, 65793);
        compute_at(2, 1, 3);
        load_weight(MAX_RADIUS, MAX_RADIUS, 65794);
        compute_at(2, 1, 3);
        write_pixel(2, 1, 3, 0);
        compute_at(2, 1, 3);
        load_weight(MAX_RADIUS, MAX_RADIUS, 262143);
        write_pixel(2, 1, 3, 1);
        compute_at(2, 1, 3);
        load_weight(7, MAX_RADIUS, 0);
        load_weight(MAX_RADIUS, 7, 0);
        load_weight(7, 7, 0);
        compute_at(2, 1, 3);
        write_pixel(3, 1, 3, 9);
        write_pixel(2, 2, 3, 9);
        compute_at(3, 1, 3);
        compute_at(2, 2, 0);
        load_weight(MAX_RADIUS, MAX_RADIUS, 0);
        write_pixel(2, 1, 3, 255);
        compute_at(2, 1, 3);
    endtask

    task automatic compute_sequence(bit anywhere);
        int c;
        int r;
        int ch;
        c  = anywhere ? $urandom_range(0, 255) : pick_coord(eff_width());
        r  = anywhere ? $urandom_range(0, 255) : pick_coord(eff_height());
        ch = pick_channel();
        fill_window(c, r, ch);
        if ($urandom_range(0, 3) == 0) write_pixel(c, r, ch, $urandom_range(0, 255));
        compute_at(c, r, ch);
    endtask

    task automatic random_step(int scale);
        int roll;
        t_blur_req q;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            compute_sequence(1'b0);
        end else if (roll < 72) begin
            load_weight($urandom_range(0, 7), $urandom_range(0, 7),
                        ($urandom_range(0, 4) == 0) ? $urandom_range(0, 262143)
                                                    : $urandom_range(0, scale));
        end else if (roll < 86) begin
            write_pixel(pick_coord(eff_width()), pick_coord(eff_height()), pick_channel(),
                        $urandom_range(0, 255));
        end else if (roll < 92) begin
            q = random_fields();
            q.op = OP_UNUSED;
            send_request(q);
        end else if (roll < 96) begin
            compute_sequence(1'b1);
        end else begin
            burst_left = $urandom_range(10, 30);
        end
    endtask

    task automatic random_phase(int w, int h, int nc, int rad, int count, int scale);
        set_geometry(w, h, nc, rad);
        load_kernel(scale);
        useful_count = 0;
        while (useful_count < count) random_step(scale);
    endtask

    // receiver holds off while back-to-back computes fill the block
    task automatic test_backpressure();
        hold_request = 1'b1;
        burst_left = 1000;
        repeat (40) compute_sequence(1'b0);
        burst_left = 0;
    endtask

    initial begin
        int n;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            n = (burst_left > 0) ? 0 : $urandom_range(0, 5);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(negedge clk);
            while (!out_valid) @(negedge clk);
            @(posedge clk);
        end
    end

    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result blurred_value %0d saturated %0d",
                         $time, blurred, saturated);
                mismatch_count++;
            end else begin
                expected_head = pending_pixels.pop_front();
                if (blurred !== expected_head.value) begin
                    $display("%0t: blurred_value expected %0d got %0d",
                             $time, expected_head.value, blurred);
                    mismatch_count++;
                end
                if (saturated !== expected_head.sat) begin
                    $display("%0t: saturated expected %0d got %0d",
                             $time, expected_head.sat, saturated);
                    mismatch_count++;
                end
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_default_geometry();
        test_saturation_edge();
        random_phase(256, 256, 4, 3, 260, 9000);
        random_phase(1, 1, 1, 0, 90, 60000);
        random_phase(5, 7, 3, 2, 220, 14000);
        test_backpressure();
        random_phase(256, 1, 2, 1, 190, 25000);
        random_phase(1, 256, 4, 3, 190, 9000);
        random_phase(511, 300, 7, 2, 190, 14000);
        random_phase(0, 0, 0, 1, 30, 20000);
        drain();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
